// ----- rtl/fhyst_pkg.sv -----
// Shared types, tables and helpers for the fan level hysteresis block.
`default_nettype none
package fhyst_pkg;

	// Number of fan levels the sequencer may use; rows past the table reuse the last row.
	localparam int NUM_LEVELS = 7;
	localparam int ROWS       = 7;
	localparam int NUM_SENS   = 3;
	localparam int LEVEL_W    = $clog2(NUM_LEVELS + 1);
	localparam int ROW_W      = $clog2(ROWS);

	// Sensor order within the tables: SoC, charger, memory.
	localparam int SENS_SOC = 0;
	localparam int SENS_CHG = 1;
	localparam int SENS_MEM = 2;

	typedef logic signed [7:0] temp_t;
	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [ROW_W-1:0] row_t;

	// Step-up thresholds, [sensor][row].
	localparam logic signed [7:0] TRIG_TBL [NUM_SENS][ROWS] = '{
		'{8'sd47, 8'sd48, 8'sd49, 8'sd50, 8'sd51, 8'sd52, 8'sd100},
		'{8'sd58, 8'sd58, 8'sd58, 8'sd58, 8'sd59, 8'sd60, 8'sd100},
		'{8'sd48, 8'sd49, 8'sd50, 8'sd51, 8'sd52, 8'sd53, 8'sd100}
	};

	// Step-down thresholds, [sensor][row].
	localparam logic signed [7:0] REL_TBL [NUM_SENS][ROWS] = '{
		'{8'sd99, 8'sd46, 8'sd47, 8'sd48, 8'sd49, 8'sd50, 8'sd51},
		'{8'sd99, 8'sd99, 8'sd99, 8'sd99, 8'sd58, 8'sd58, 8'sd59},
		'{8'sd99, 8'sd47, 8'sd48, 8'sd49, 8'sd50, 8'sd51, 8'sd52}
	};

	localparam logic [15:0] RPM_TBL [ROWS] = '{
		16'd0, 16'd3400, 16'd4000, 16'd4300, 16'd4450, 16'd4700, 16'd5500
	};

	typedef struct packed {
		temp_t temp_soc;
		temp_t temp_charger;
		temp_t temp_memory;
		logic  system_on;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] fan_rpm;
		logic [2:0]  fan_level;
		logic        applied;
	} out_beat_t;

	// What one sensor lane reports for the current level.
	typedef struct packed {
		logic fell;
		logic rose;
		logic below_rel;
		logic above_trig;
	} lane_flags_t;

	// Lane results combined across sensors.
	typedef struct packed {
		logic any_fell;
		logic any_rose;
		logic all_below;
		logic any_above;
	} merge_flags_t;

	// Table row used by a level: levels past the table share the last row.
	function automatic row_t row_of(input level_t lv);
		row_t r;
		if (int'(lv) >= ROWS) begin
			r = row_t'(ROWS - 1);
		end else begin
			r = row_t'(lv);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/fhyst_lane.sv -----
// One sensor lane: compares a temperature with its history and the level thresholds.
`default_nettype none
module fhyst_lane (
	input  wire logic signed [7:0]   temp,
	input  wire logic signed [7:0]   prev,
	input  wire logic signed [7:0]   trig,
	input  wire logic signed [7:0]   rel,
	output fhyst_pkg::lane_flags_t   flags
);

	// Signed compares against history and the current row
	always_comb begin
		flags.fell       = temp < prev;
		flags.rose       = temp > prev;
		flags.below_rel  = temp < rel;
		flags.above_trig = temp > trig;
	end

endmodule
`default_nettype wire

// ----- rtl/fhyst_merge.sv -----
// Merge stage: folds the sensor lane flags into the step decisions.
`default_nettype none
module fhyst_merge (
	input  wire fhyst_pkg::lane_flags_t [fhyst_pkg::NUM_SENS-1:0] lanes,
	output fhyst_pkg::merge_flags_t                               merged
);

	// Down needs every sensor below release; up needs any above trigger
	always_comb begin
		merged.any_fell  = 1'b0;
		merged.any_rose  = 1'b0;
		merged.all_below = 1'b1;
		merged.any_above = 1'b0;
		for (int k = 0; k < fhyst_pkg::NUM_SENS; k++) begin
			merged.any_fell  = merged.any_fell | lanes[k].fell;
			merged.any_rose  = merged.any_rose | lanes[k].rose;
			merged.all_below = merged.all_below & lanes[k].below_rel;
			merged.any_above = merged.any_above | lanes[k].above_trig;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/fan_level_hysteresis_table_core.sv -----
// Top level: fan level sequencer with hysteresis and RPM lookup.
//
// Input channel (in, in_valid, in_stall): one beat carries three signed
// temperatures and the system_on flag. Output channel (out, out_valid,
// out_stall): one beat per input beat with fan_rpm, fan_level and applied.
// A beat is taken on an edge where valid is high and stall is low.
//
// Sequence: a decide state, then a walk state that takes one level step at
// a time and ends with the step that stops the walk, then a finish state
// that loads the output register. The walk is skipped when the system is
// off or no temperature moved. The walk over the level table is the limit:
// three sensor lanes check one level a cycle. One beat is in work at a
// time; in_stall is high from acceptance until the result is loaded into
// the output register, so the core takes no new input beat before it is
// through with the last one.
//
// Reset clears the level and stored temperatures to zero and empties the
// output register. A stalled receiver holds the result in the output
// register; a new beat may be accepted meanwhile and waits at its final
// cycle until the register frees.
`default_nettype none
module fan_level_hysteresis_table_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire fhyst_pkg::in_beat_t   in,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	output fhyst_pkg::out_beat_t       out,
	output logic                       out_valid,
	input  wire logic                  out_stall
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_WALK,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   down_q;
	logic   on_q;

	fhyst_pkg::level_t level_q;
	fhyst_pkg::temp_t  temps_q [fhyst_pkg::NUM_SENS];
	fhyst_pkg::temp_t  prev_q  [fhyst_pkg::NUM_SENS];
	fhyst_pkg::out_beat_t out_q;
	logic out_valid_q;

	fhyst_pkg::row_t row;
	fhyst_pkg::lane_flags_t [fhyst_pkg::NUM_SENS-1:0] lane_flags;
	fhyst_pkg::merge_flags_t merged;
	fhyst_pkg::level_t level_clamped;
	logic out_free;
	logic load_out;
	logic at_top;
	logic at_bottom;

	assign row = fhyst_pkg::row_of(level_q);

	// Sensor lanes against the row of the current level
	for (genvar k = 0; k < fhyst_pkg::NUM_SENS; k++) begin : g_lane
		fhyst_lane u_lane (
			.temp  (temps_q[k]),
			.prev  (prev_q[k]),
			.trig  (fhyst_pkg::TRIG_TBL[k][row]),
			.rel   (fhyst_pkg::REL_TBL[k][row]),
			.flags (lane_flags[k])
		);
	end

	fhyst_merge u_merge (
		.lanes  (lane_flags),
		.merged (merged)
	);

	// Walk limits and final clamp
	assign at_top    = level_q >= fhyst_pkg::level_t'(fhyst_pkg::NUM_LEVELS);
	assign at_bottom = level_q == '0;
	assign level_clamped = at_top ? fhyst_pkg::level_t'(fhyst_pkg::NUM_LEVELS - 1) : level_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign load_out  = (state_q == ST_FINISH) && out_free;
	assign in_stall  = state_q != ST_IDLE;
	assign out       = out_q;
	assign out_valid = out_valid_q;

	// Sequencer, level state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			level_q     <= '0;
			down_q      <= 1'b0;
			on_q        <= 1'b0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < fhyst_pkg::NUM_SENS; k++) begin
				prev_q[k]  <= '0;
				temps_q[k] <= '0;
			end
		end else begin
			// Output valid: set on load, cleared once the beat is taken
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						temps_q[fhyst_pkg::SENS_SOC] <= in.temp_soc;
						temps_q[fhyst_pkg::SENS_CHG] <= in.temp_charger;
						temps_q[fhyst_pkg::SENS_MEM] <= in.temp_memory;
						on_q    <= in.system_on;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					// Falling temperature takes priority over rising
					down_q <= merged.any_fell;
					if (on_q && (merged.any_fell || merged.any_rose)) begin
						state_q <= ST_WALK;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_WALK: begin
					if (down_q) begin
						if (!at_bottom && merged.all_below) begin
							level_q <= level_q - fhyst_pkg::level_t'(1);
						end else begin
							state_q <= ST_FINISH;
						end
					end else begin
						if (!at_top && merged.any_above) begin
							level_q <= level_q + fhyst_pkg::level_t'(1);
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (load_out) begin
						if (on_q) begin
							level_q <= level_clamped;
							for (int k = 0; k < fhyst_pkg::NUM_SENS; k++) begin
								prev_q[k] <= temps_q[k];
							end
						end
						out_q.fan_rpm   <= fhyst_pkg::RPM_TBL[fhyst_pkg::row_of(level_clamped)];
						out_q.fan_level <= 3'(level_clamped);
						out_q.applied   <= on_q;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- dv/fan_level_hysteresis_table_core_test.sv -----
`timescale 1ns / 1ps
// Testbench for the fan level hysteresis core: a directed table, then random temperature walks.
module fan_level_hysteresis_table_core_test;

	localparam int RANDOM_BEATS = 1150;
	localparam int QUIET_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 20;
	localparam int LAST_ROW     = 6;

	// Per-row thresholds, sensor order SoC, charger, memory.
	localparam int UP_LIMIT [7][3] = '{
		'{47, 58, 48}, '{48, 58, 49}, '{49, 58, 50}, '{50, 58, 51},
		'{51, 59, 52}, '{52, 60, 53}, '{100, 100, 100}
	};
	localparam int DOWN_LIMIT [7][3] = '{
		'{99, 99, 99}, '{46, 99, 47}, '{47, 99, 48}, '{48, 99, 49},
		'{49, 58, 50}, '{50, 58, 51}, '{51, 59, 52}
	};
	localparam int ROW_RPM [7] = '{0, 3400, 4000, 4300, 4450, 4700, 5500};

	typedef struct packed {
		fhyst_pkg::in_beat_t  beat;
		logic                 typed_in;
		fhyst_pkg::out_beat_t want;
	} dir_step_t;

	// Directed table; rows with typed_in set carry their own expected result.
	localparam int DIR_STEPS = 21;
	localparam dir_step_t DIRECTED [DIR_STEPS] = '{
		// off right after reset: held at level 0
		'{'{8'sd127, 8'sd127, 8'sd127, 1'b0}, 1'b1, '{16'd0, 3'd0, 1'b0}},
		// temperatures unchanged from reset
		'{'{8'sd0, 8'sd0, 8'sd0, 1'b1}, 1'b1, '{16'd0, 3'd0, 1'b1}},
		// full heat: walks past the top and clamps
		'{'{8'sd127, 8'sd127, 8'sd127, 1'b1}, 1'b1, '{16'd5500, 3'd6, 1'b1}},
		'{'{8'sh80, 8'sh80, 8'sh80, 1'b0}, 1'b1, '{16'd5500, 3'd6, 1'b0}},
		'{'{8'sd127, 8'sd127, 8'sd127, 1'b1}, 1'b1, '{16'd5500, 3'd6, 1'b1}},
		// full cold: walks all the way down
		'{'{8'sh80, 8'sh80, 8'sh80, 1'b1}, 1'b1, '{16'd0, 3'd0, 1'b1}},
		// trigger edges, one sensor at a time
		'{'{8'sd48, 8'sd0, 8'sd0, 1'b1}, 1'b0, '0},
		'{'{8'sd48, 8'sd59, 8'sd0, 1'b1}, 1'b0, '0},
		'{'{8'sd48, 8'sd58, 8'sd0, 1'b1}, 1'b0, '0},
		'{'{8'sd48, 8'sd57, 8'sd0, 1'b1}, 1'b0, '0},
		// sensors fall while others rise: falling wins
		'{'{8'sd0, 8'sd127, -8'sd5, 1'b1}, 1'b0, '0},
		'{'{8'sd127, 8'sh80, 8'sd127, 1'b1}, 1'b0, '0},
		'{'{-8'sd1, -8'sd1, -8'sd1, 1'b1}, 1'b0, '0},
		'{'{-8'sd1, -8'sd1, -8'sd1, 1'b1}, 1'b0, '0},
		'{'{8'sd52, 8'sd0, 8'sd0, 1'b1}, 1'b0, '0},
		'{'{8'sd53, 8'sd0, 8'sd0, 1'b1}, 1'b0, '0},
		// top row trigger crossed by memory only: clamp
		'{'{8'sd53, 8'sd0, 8'sd101, 1'b1}, 1'b1, '{16'd5500, 3'd6, 1'b1}},
		'{'{8'sd0, 8'sd0, 8'sd0, 1'b0}, 1'b1, '{16'd5500, 3'd6, 1'b0}},
		'{'{8'sd50, 8'sd58, 8'sd51, 1'b1}, 1'b0, '0},
		// alternating bit patterns
		'{'{8'shAA, 8'sh55, 8'shAA, 1'b1}, 1'b0, '0},
		'{'{8'sh55, 8'shAA, 8'sh55, 1'b1}, 1'b0, '0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	fhyst_pkg::in_beat_t  in_beat;
	logic                 in_valid;
	logic                 in_stall;
	fhyst_pkg::out_beat_t out_beat;
	logic                 out_valid;
	logic                 out_stall;

	int send_idle_pct;
	int recv_stall_pct;
	fhyst_pkg::out_beat_t pending_fan_q [$];

	// Predictor state
	int fan_lvl;
	int last_temp [3];
	int walk_temp [3];

	int err_count;
	int results_checked;
	int beats_sent;
	int held_count;
	int quiet_cycles;

	fan_level_hysteresis_table_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (in_beat),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out       (out_beat),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

	always #5 clk = ~clk;

	// Level walk with hysteresis; updates the predictor state.
	function automatic fhyst_pkg::out_beat_t predict_fan(input fhyst_pkg::in_beat_t b);
		int t [3];
		int r;
		bit fell;
		bit rose;
		bit moving;
		fhyst_pkg::out_beat_t res;
		t[0] = int'($signed(b.temp_soc));
		t[1] = int'($signed(b.temp_charger));
		t[2] = int'($signed(b.temp_memory));
		fell = 1'b0;
		rose = 1'b0;
		moving = 1'b1;
		if (b.system_on) begin
			for (int k = 0; k < 3; k++) begin
				if (t[k] < last_temp[k]) fell = 1'b1;
				if (t[k] > last_temp[k]) rose = 1'b1;
			end
			if (fell) begin
				// down while all three sit under the release points
				while (moving && fan_lvl > 0) begin
					r = (fan_lvl > LAST_ROW) ? LAST_ROW : fan_lvl;
					if (t[0] < DOWN_LIMIT[r][0] && t[1] < DOWN_LIMIT[r][1] &&
					    t[2] < DOWN_LIMIT[r][2]) begin
						fan_lvl--;
					end else begin
						moving = 1'b0;
					end
				end
			end else if (rose) begin
				// up while any one is over the trigger points
				while (moving && fan_lvl < fhyst_pkg::NUM_LEVELS) begin
					r = (fan_lvl > LAST_ROW) ? LAST_ROW : fan_lvl;
					if (t[0] > UP_LIMIT[r][0] || t[1] > UP_LIMIT[r][1] ||
					    t[2] > UP_LIMIT[r][2]) begin
						fan_lvl++;
					end else begin
						moving = 1'b0;
					end
				end
			end
			if (fan_lvl >= fhyst_pkg::NUM_LEVELS) fan_lvl = fhyst_pkg::NUM_LEVELS - 1;
			for (int k = 0; k < 3; k++) last_temp[k] = t[k];
		end
		r = (fan_lvl > LAST_ROW) ? LAST_ROW : fan_lvl;
		res.fan_rpm   = 16'(ROW_RPM[r]);
		res.fan_level = 3'(fan_lvl);
		res.applied   = b.system_on;
		return res;
	endfunction

	// Mostly slow drifts around the thresholds, some jumps, repeats, noise and off beats.
	function automatic fhyst_pkg::in_beat_t next_reading();
		fhyst_pkg::in_beat_t b;
		int pick;
		int v;
		pick = $urandom_range(0, 99);
		if (pick < 16) begin
			b.temp_soc     = 8'($urandom);
			b.temp_charger = 8'($urandom);
			b.temp_memory  = 8'($urandom);
			b.system_on    = (pick >= 9);
			return b;
		end
		if (pick < 24) begin
			for (int k = 0; k < 3; k++) walk_temp[k] = $urandom_range(30, 110);
		end else if (pick >= 34) begin
			for (int k = 0; k < 3; k++) begin
				v = walk_temp[k] + int'($urandom_range(0, 6)) - 3;
				walk_temp[k] = (v < 20) ? 20 : ((v > 110) ? 110 : v);
			end
		end
		b.temp_soc     = 8'(walk_temp[0]);
		b.temp_charger = 8'(walk_temp[1]);
		b.temp_memory  = 8'(walk_temp[2]);
		b.system_on    = 1'b1;
		return b;
	endfunction

	// Offer one beat from a falling edge; returns at the falling edge after acceptance.
	task automatic drive_beat(input fhyst_pkg::in_beat_t b, input logic typed_in,
	                          input fhyst_pkg::out_beat_t want);
		fhyst_pkg::out_beat_t p;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_beat  <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		p = predict_fan(b);
		pending_fan_q.push_back(typed_in ? want : p);
		beats_sent++;
		if (!b.system_on) held_count++;
		@(negedge clk);
	endtask

	// Receiver stall
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Result check against the oldest pending expectation
	always @(posedge clk) begin
		fhyst_pkg::out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_fan_q.size() == 0) begin
				$display("%0t: ERROR unexpected result rpm %0d level %0d applied %0b",
				         $time, out_beat.fan_rpm, out_beat.fan_level, out_beat.applied);
				err_count++;
			end else begin
				want = pending_fan_q.pop_front();
				results_checked++;
				if (out_beat.fan_rpm !== want.fan_rpm) begin
					$display("%0t: ERROR fan_rpm expected %0d, got %0d",
					         $time, want.fan_rpm, out_beat.fan_rpm);
					err_count++;
				end
				if (out_beat.fan_level !== want.fan_level) begin
					$display("%0t: ERROR fan_level expected %0d, got %0d",
					         $time, want.fan_level, out_beat.fan_level);
					err_count++;
				end
				if (out_beat.applied !== want.applied) begin
					$display("%0t: ERROR applied expected %0b, got %0b",
					         $time, want.applied, out_beat.applied);
					err_count++;
				end
			end
		end
	end

	// Watchdog: too long with no beat moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: ERROR no beat moved for %0d cycles", $time, QUIET_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_beat   = '0;
		out_stall = 1'b0;
		fan_lvl   = 0;
		for (int k = 0; k < 3; k++) begin
			last_temp[k] = 0;
			walk_temp[k] = 40;
		end
		err_count       = 0;
		results_checked = 0;
		beats_sent      = 0;
		held_count      = 0;
		quiet_cycles    = 0;
		send_idle_pct   = 16;
		recv_stall_pct  = 51;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_STEPS; i++) begin
			drive_beat(DIRECTED[i].beat, DIRECTED[i].typed_in, DIRECTED[i].want);
		end

		// Three idle mixes: slow receiver, slow sender, none
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 16;
					recv_stall_pct = 51;
				end
				1: begin
					send_idle_pct  = 51;
					recv_stall_pct = 16;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int i = 0; i < RANDOM_BEATS / 3; i++) begin
				drive_beat(next_reading(), 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		while (pending_fan_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Drove %0d temperature beats (%0d with the system off), checked %0d results",
		         beats_sent, held_count, results_checked);
		$display("over directed edges and random walks under three idle/stall mixes.");
		if (err_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
